FILE: src/ndre_pkg.sv
// shared types and constants of the run list decoder
// no dependencies
package ndre_pkg;

    localparam int unsigned MAX_FIELD_BYTES = 8;
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned CFG_IDX_W       = 1;
    localparam int unsigned CFG_DATA_W      = 64;

    localparam logic [23:0] CLUSTER_BYTES_RESET = 24'd4096;
    localparam logic [62:0] VOL_BASE_RESET      = 63'd0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_BASE      = 1'd1;

    // result kinds
    localparam logic [2:0] K_EXTENT = 3'd0;
    localparam logic [2:0] K_END    = 3'd1;
    localparam logic [2:0] K_EMPTY  = 3'd2;
    localparam logic [2:0] K_BADHDR = 3'd3;
    localparam logic [2:0] K_TRUNC  = 3'd4;
    localparam logic [2:0] K_NEGCL  = 3'd5;

    // command from parser to extent builder
    typedef struct packed {
        logic        clr;       // logical position restarts at zero
        logic        is_run;    // complete run, else a status
        logic [2:0]  kind;      // status kind
        logic        extent;    // run has offset bytes
        logic        end_flag;  // buffer ended right after this run
        logic [63:0] length;    // run length in clusters
        logic [62:0] lcn;       // cluster number of the run
    } t_cmd;

    // control part of a command as it moves through the back pipeline
    typedef struct packed {
        logic       clr;
        logic       is_run;
        logic [2:0] kind;
        logic       extent;
        logic       end_flag;
    } t_ctl;

endpackage

FILE: src/ndre_front.sv
// byte parser: header decode, field gathering, cluster number accumulation
// depends on ndre_pkg
module ndre_front
    import ndre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_first,
    input  logic        i_last,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam logic [1:0] PH_FINISHED = 2'd0;
    localparam logic [1:0] PH_HEADER   = 2'd1;
    localparam logic [1:0] PH_FIELDS   = 2'd2;
    localparam logic [3:0] MAX_SIZE    = 4'(MAX_FIELD_BYTES);

    logic [1:0]  r_phase, n_phase;
    logic [3:0]  r_ls, n_ls;
    logic [3:0]  r_os, n_os;
    logic [3:0]  r_pos, n_pos;
    logic [63:0] r_len, n_len;
    logic [63:0] r_off, n_off;
    logic [63:0] r_cluster, n_cluster;
    logic        r_any, n_any;
    logic        r_clr, n_clr;

    logic        accept;
    logic [1:0]  eff_phase;
    logic [63:0] eff_cluster;
    logic        eff_any;
    logic        eff_clr;
    logic [3:0]  hdr_ls, hdr_os;
    logic [3:0]  off_pos;
    logic [63:0] len_new, off_new, raw, lcn;
    logic        sign_ext;
    logic        final_byte;
    logic        push;
    t_cmd        cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign hdr_ls  = i_byte[3:0];
    assign hdr_os  = i_byte[7:4];
    assign off_pos = r_pos - r_ls;

    always_comb begin
        eff_phase   = i_first ? PH_HEADER : r_phase;
        eff_cluster = i_first ? 64'd0 : r_cluster;
        eff_any     = i_first ? 1'b0 : r_any;
        eff_clr     = i_first || r_clr;

        // byte lanes of the two little-endian fields
        sign_ext = (r_os != 4'd0) && (r_os < 4'd8) && i_byte[7];
        for (int k = 0; k < 8; k++) begin
            len_new[8*k +: 8] = r_len[8*k +: 8];
            off_new[8*k +: 8] = r_off[8*k +: 8];
            if ((r_pos < r_ls) && (r_pos[2:0] == 3'(k))) begin
                len_new[8*k +: 8] = r_len[8*k +: 8] | i_byte;
            end
            if ((r_pos >= r_ls) && (off_pos[2:0] == 3'(k))) begin
                off_new[8*k +: 8] = r_off[8*k +: 8] | i_byte;
            end
            raw[8*k +: 8] = (sign_ext && (4'(k) >= r_os)) ? 8'hff : off_new[8*k +: 8];
        end
        lcn        = eff_cluster + raw;
        final_byte = (5'(r_pos) + 5'd1) == (5'(r_ls) + 5'(r_os));
    end

    always_comb begin
        n_phase   = r_phase;
        n_ls      = r_ls;
        n_os      = r_os;
        n_pos     = r_pos;
        n_len     = r_len;
        n_off     = r_off;
        n_cluster = r_cluster;
        n_any     = r_any;
        push      = 1'b0;
        cmd.clr      = eff_clr;
        cmd.is_run   = 1'b0;
        cmd.kind     = K_END;
        cmd.extent   = 1'b0;
        cmd.end_flag = 1'b0;
        cmd.length   = len_new;
        cmd.lcn      = lcn[62:0];

        if (accept) begin
            n_phase   = eff_phase;
            n_cluster = eff_cluster;
            n_any     = eff_any;
            case (eff_phase)
                PH_HEADER: begin
                    if (i_byte == 8'd0) begin
                        push     = 1'b1;
                        cmd.kind = eff_any ? K_END : K_EMPTY;
                        n_phase  = PH_FINISHED;
                    end else if (hdr_ls == 4'd0 || hdr_ls > MAX_SIZE || hdr_os > MAX_SIZE) begin
                        push     = 1'b1;
                        cmd.kind = K_BADHDR;
                        n_phase  = PH_FINISHED;
                    end else if (i_last) begin
                        push     = 1'b1;
                        cmd.kind = K_TRUNC;
                        n_phase  = PH_FINISHED;
                    end else begin
                        n_ls    = hdr_ls;
                        n_os    = hdr_os;
                        n_pos   = 4'd0;
                        n_len   = 64'd0;
                        n_off   = 64'd0;
                        n_phase = PH_FIELDS;
                    end
                end
                PH_FIELDS: begin
                    n_len = len_new;
                    n_off = off_new;
                    if (final_byte) begin
                        push = 1'b1;
                        if (lcn[63]) begin
                            cmd.kind = K_NEGCL;
                            n_phase  = PH_FINISHED;
                        end else begin
                            cmd.is_run   = 1'b1;
                            cmd.extent   = (r_os != 4'd0);
                            cmd.end_flag = i_last;
                            n_cluster    = lcn;
                            n_any        = 1'b1;
                            n_phase      = i_last ? PH_FINISHED : PH_HEADER;
                        end
                    end else begin
                        n_pos = r_pos + 4'd1;
                        if (i_last) begin
                            push     = 1'b1;
                            cmd.kind = K_TRUNC;
                            n_phase  = PH_FINISHED;
                        end
                    end
                end
                default: begin
                    // finished: bytes ignored until the next first byte
                end
            endcase
        end
        n_clr = accept ? (eff_clr && !push) : r_clr;
    end

    assign o_push = push;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FINISHED;
            r_ls      <= 4'd0;
            r_os      <= 4'd0;
            r_pos     <= 4'd0;
            r_len     <= 64'd0;
            r_off     <= 64'd0;
            r_cluster <= 64'd0;
            r_any     <= 1'b0;
            r_clr     <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_ls      <= n_ls;
            r_os      <= n_os;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_off     <= n_off;
            r_cluster <= n_cluster;
            r_any     <= n_any;
            r_clr     <= n_clr;
        end
    end

endmodule

FILE: src/ndre_fifo.sv
// command queue between parser and extent builder
// depends on ndre_pkg
module ndre_fifo
    import ndre_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command queue read while empty");

endmodule

FILE: src/ndre_back.sv
// extent builder: cluster size products, logical position, result register
// depends on ndre_pkg
module ndre_back
    import ndre_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [23:0]  i_cluster_bytes,
    input  logic [62:0]  i_vol_base,
    input  logic         i_q_empty,
    input  t_cmd         i_cmd,
    output logic         o_pop,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [2:0]   o_kind,
    output logic [63:0]  o_logical,
    output logic [63:0]  o_physical,
    output logic [63:0]  o_length,
    output logic         o_final
);

    // stage 1: partial products
    logic        r_s1_v;
    t_ctl        r_s1_ctl;
    logic [55:0] r_p_len_lo, r_p_lcn_lo;
    logic [31:0] r_p_len_hi, r_p_lcn_hi;
    // stage 2: wrapped 64-bit products
    logic        r_s2_v;
    t_ctl        r_s2_ctl;
    logic [63:0] r_bytes, r_lcnb;
    // output register and the end status that may follow an extent
    logic        r_o_v;
    logic [2:0]  r_o_kind;
    logic [63:0] r_o_log, r_o_phys, r_o_len;
    logic        r_o_fin;
    logic        r_pend;
    logic [63:0] r_pend_log;
    logic [63:0] r_logical;

    logic        out_take, out_free, s2_go, s2_ready, s1_go, s1_ready, pop;
    logic [63:0] base, next_log;
    logic [55:0] mul_len_lo, mul_lcn_lo;
    logic [31:0] mul_len_hi, mul_lcn_hi;
    t_ctl        in_ctl;

    assign out_take = r_o_v && i_ready;
    assign out_free = !r_pend && (!r_o_v || out_take);
    assign s2_go    = r_s2_v && out_free;
    assign s2_ready = !r_s2_v || s2_go;
    assign s1_go    = r_s1_v && s2_ready;
    assign s1_ready = !r_s1_v || s1_go;
    assign pop      = !i_q_empty && s1_ready;
    assign o_pop    = pop;

    assign in_ctl.clr      = i_cmd.clr;
    assign in_ctl.is_run   = i_cmd.is_run;
    assign in_ctl.kind     = i_cmd.kind;
    assign in_ctl.extent   = i_cmd.extent;
    assign in_ctl.end_flag = i_cmd.end_flag;

    // upper halves only matter below bit 64, so keep their low 32 bits
    assign mul_len_lo = 56'(i_cmd.length[31:0]) * 56'(i_cluster_bytes);
    assign mul_len_hi = 32'(i_cmd.length[63:32]) * 32'(i_cluster_bytes);
    assign mul_lcn_lo = 56'(i_cmd.lcn[31:0]) * 56'(i_cluster_bytes);
    assign mul_lcn_hi = 32'(i_cmd.lcn[62:32]) * 32'(i_cluster_bytes);

    assign base     = r_s2_ctl.clr ? 64'd0 : r_logical;
    assign next_log = base + r_bytes;

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_ctl   <= in_ctl;
            r_p_len_lo <= mul_len_lo;
            r_p_len_hi <= mul_len_hi;
            r_p_lcn_lo <= mul_lcn_lo;
            r_p_lcn_hi <= mul_lcn_hi;
        end
        if (s1_go) begin
            r_s2_ctl <= r_s1_ctl;
            r_bytes  <= 64'(r_p_len_lo) + {r_p_len_hi, 32'd0};
            r_lcnb   <= 64'(r_p_lcn_lo) + {r_p_lcn_hi, 32'd0};
        end
        if (out_take && r_pend) begin
            r_o_kind <= K_END;
            r_o_log  <= r_pend_log;
            r_o_phys <= 64'd0;
            r_o_len  <= 64'd0;
            r_o_fin  <= 1'b1;
        end else if (s2_go) begin
            if (!r_s2_ctl.is_run) begin
                r_o_kind <= r_s2_ctl.kind;
                r_o_log  <= base;
                r_o_phys <= 64'd0;
                r_o_len  <= 64'd0;
                r_o_fin  <= 1'b1;
            end else if (r_s2_ctl.extent) begin
                r_o_kind <= K_EXTENT;
                r_o_log  <= base;
                r_o_phys <= 64'(i_vol_base) + r_lcnb;
                r_o_len  <= r_bytes;
                r_o_fin  <= !r_s2_ctl.end_flag;
            end else begin
                r_o_kind <= K_END;
                r_o_log  <= next_log;
                r_o_phys <= 64'd0;
                r_o_len  <= 64'd0;
                r_o_fin  <= 1'b1;
            end
        end
        if (s2_go) begin
            r_pend_log <= next_log;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_o_v     <= 1'b0;
            r_pend    <= 1'b0;
            r_logical <= 64'd0;
        end else begin
            if (s1_ready) begin
                r_s1_v <= pop;
            end
            if (s2_ready) begin
                r_s2_v <= s1_go;
            end
            if (s2_go) begin
                r_logical <= r_s2_ctl.is_run ? next_log : base;
            end
            if (out_take && r_pend) begin
                r_o_v  <= 1'b1;
                r_pend <= 1'b0;
            end else if (s2_go && (!r_s2_ctl.is_run || r_s2_ctl.extent
                                   || r_s2_ctl.end_flag)) begin
                r_o_v  <= 1'b1;
                r_pend <= r_s2_ctl.is_run && r_s2_ctl.extent && r_s2_ctl.end_flag;
            end else if (out_take) begin
                r_o_v <= 1'b0;
            end
        end
    end

    assign o_valid    = r_o_v;
    assign o_kind     = r_o_kind;
    assign o_logical  = r_o_log;
    assign o_physical = r_o_phys;
    assign o_length   = r_o_len;
    assign o_final    = r_o_fin;

    a_pend_behind_extent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_o_v && (r_o_kind == K_EXTENT) && !r_o_fin))
        else $error("pending end status without an extent in the output register");

    a_pend_no_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !s2_go)
        else $error("new command taken while an end status is pending");

endmodule

FILE: src/ntfs_data_run_extent_decoder_top.sv
// Decoder for NTFS run lists (mapping pairs), one byte per cycle. Each
// complete run with offset bytes yields an extent (logical byte offset,
// device byte offset, byte length); sparse runs only advance the logical
// offset. A zero header or the buffer end yields an end status; a bad
// header, truncation or a negative cluster number yields an error status,
// after which extents already delivered for that list are to be dropped.
// The parser takes one byte per cycle whenever the four-entry command
// queue has room; the extent builder behind it is a three-stage pipeline
// (split cluster-size products, 64-bit sums, output register) and drains
// one command per cycle while the output is taken, except that an extent
// followed by its end status occupies the output for two transfers. With
// an idle output an extent's command passes the command queue, the partial
// product, sum and output registers, in that order, before it is valid.
// Registers: index 0 cluster_bytes (24 bits, reset 4096), index 1 volume
// base offset (63 bits, reset 0); write them only while the block is idle.
// depends on ndre_pkg, ndre_front, ndre_fifo, ndre_back
module ntfs_data_run_extent_decoder_top
    import ndre_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = QUEUE_DEPTH
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // run list bytes
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] data_byte
    input  logic                  i_s_tuser,   // [0] first
    input  logic                  i_s_tlast,   // last byte of the buffer
    // results
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [191:0]          o_m_tdata,   // [63:0] logical_offset,
                                               // [127:64] physical_offset,
                                               // [191:128] byte_length
    output logic [2:0]            o_m_tuser,   // [2:0] kind
    output logic                  o_m_tlast,   // final_of_item
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [23:0] r_cluster_bytes;
    logic [62:0] r_vol_base;

    logic push, pop, q_full, q_empty;
    t_cmd f_cmd, q_cmd;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_bytes <= CLUSTER_BYTES_RESET;
            r_vol_base      <= VOL_BASE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CLUSTER_BYTES: r_cluster_bytes <= i_cfg_data[23:0];
                REG_VOL_BASE:      r_vol_base      <= i_cfg_data[62:0];
                default: begin
                end
            endcase
        end
    end

    // front: header decode and field gathering, one transfer per cycle while the queue has room
    ndre_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_byte   (i_s_tdata),
        .i_first  (i_s_tuser),
        .i_last   (i_s_tlast),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (f_cmd)
    );

    // queue decouples the parser from the output side
    ndre_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // back: byte products, logical position and result transfers
    ndre_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cluster_bytes (r_cluster_bytes),
        .i_vol_base      (r_vol_base),
        .i_q_empty       (q_empty),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_kind          (o_m_tuser),
        .o_logical       (o_m_tdata[63:0]),
        .o_physical      (o_m_tdata[127:64]),
        .o_length        (o_m_tdata[191:128]),
        .o_final         (o_m_tlast)
    );

endmodule
